/* rtl/core/bzs_pkg.sv */
// Shared types and constants of the cubic Bezier curve sampler.
`default_nettype none

package bzs_pkg;

   // Coordinate and interpolation parameter formats.
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 16;
   localparam int T_W     = 17;
   localparam int T_ONE   = 65536;

   // Product of a 33-bit difference and an 18-bit signed t.
   localparam int PROD_W  = COORD_W + 1 + T_W + 1;
   // Shifted quotient plus one guard bit for the add.
   localparam int SUM_W   = PROD_W - FRAC_W + 1;

   // Point count register.
   localparam int DOT_W     = 7;
   localparam int DOT_RESET = 10;

   // Serial divider of T_ONE: one quotient bit per cycle.
   localparam int DIV_CNT_W = 5;
   localparam int DIV_STEPS = T_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] p0_x;
      logic signed [COORD_W-1:0] p0_y;
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      last_point;
   } rsp_payload_type;

   typedef struct packed {
      logic [DOT_W-1:0] dot_count;
   } csr_payload_type;

   // One sample handed from the sequencer to the interpolation pipeline.
   typedef struct packed {
      logic            valid;
      logic            last_point;
      logic [T_W-1:0]  t;
      req_payload_type points;
   } issue_type;

endpackage

`default_nettype wire

/* rtl/core/bzs_chan_if.sv */
// Valid/ready channel carrying one payload per handshake.
`default_nettype none

interface bzs_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* rtl/core/bzs_lerp.sv */
// Two-stage Q16.16 linear interpolation a + trunc((b - a) * t) with saturation.
`default_nettype none

module bzs_lerp (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [bzs_pkg::COORD_W-1:0] a,
   input  logic signed [bzs_pkg::COORD_W-1:0] b,
   input  logic        [bzs_pkg::T_W-1:0]     t,
   output logic signed [bzs_pkg::COORD_W-1:0] y
);
   import bzs_pkg::*;

   logic signed [COORD_W:0]       diff;
   logic signed [T_W:0]           t_s;
   logic signed [PROD_W-1:0]      prod_in;
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [COORD_W-1:0]     a_ff;
   logic signed [PROD_W-1:0]      biased;
   logic signed [SUM_W-2:0]       quo;
   logic signed [SUM_W-1:0]       sum;
   logic signed [COORD_W-1:0]     y_in;
   logic signed [COORD_W-1:0]     y_ff;

   // First stage: difference and product.
   always_comb begin
      diff    = {b[COORD_W-1], b} - {a[COORD_W-1], a};
      t_s     = {1'b0, t};
      prod_in = diff * t_s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
   end

   // Second stage: divide by 2^16 toward zero, add the base, clamp.
   always_comb begin
      biased = prod_ff[PROD_W-1] ? prod_ff + PROD_W'(T_ONE - 1) : prod_ff;
      quo    = biased[PROD_W-1:FRAC_W];
      sum    = {{(SUM_W-COORD_W){a_ff[COORD_W-1]}}, a_ff} + {quo[SUM_W-2], quo};
      if (sum[SUM_W-1:COORD_W-1] == '0 || sum[SUM_W-1:COORD_W-1] == '1) begin
         y_in = sum[COORD_W-1:0];
      end else begin
         y_in = {sum[SUM_W-1], {(COORD_W-1){~sum[SUM_W-1]}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

`default_nettype wire

/* rtl/core/bzs_seq.sv */
// Request holder, point count register, step divider and sample sequencer.
`default_nettype none

module bzs_seq #(
   parameter int MAX_DOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   bzs_chan_if.sink           req_chan,
   bzs_chan_if.sink           csr_chan,
   input  logic               adv,
   output bzs_pkg::issue_type issue
);
   import bzs_pkg::*;

   localparam int IDX_W = $clog2(MAX_DOTS);
   localparam logic [DOT_W-1:0] MAX_N = DOT_W'(MAX_DOTS);
   localparam logic [DOT_W-1:0] MIN_N = DOT_W'(2);

   logic [DOT_W-1:0]     dot_ff;
   logic [DOT_W-1:0]     n_clamp;
   logic [DOT_W-1:0]     d_full;
   logic [IDX_W-1:0]     d;

   logic                 div_busy_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [IDX_W-1:0]     div_rem_ff;
   logic [T_W-1:0]       div_quo_ff;
   logic [IDX_W:0]       rem_sh;
   logic                 div_bit;

   logic                 gen_active_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [T_W-1:0]       t_ff;
   logic [IDX_W-1:0]     acc_ff;
   logic [IDX_W:0]       acc_sum;
   logic                 last;
   req_payload_type      points_ff;

   logic                 req_fire;
   logic                 csr_fire;
   logic                 issue_fire;

   // Clamp the point count and form the divisor n - 1.
   always_comb begin
      if (dot_ff < MIN_N) begin
         n_clamp = MIN_N;
      end else if (dot_ff > MAX_N) begin
         n_clamp = MAX_N;
      end else begin
         n_clamp = dot_ff;
      end
      d_full = n_clamp - DOT_W'(1);
      d      = d_full[IDX_W-1:0];
   end

   // A register write offered in the same cycle goes ahead of a request.
   assign req_chan.ready = !gen_active_ff && !div_busy_ff && !csr_chan.valid;
   assign csr_chan.ready = !gen_active_ff && !div_busy_ff;
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign csr_fire   = csr_chan.valid && csr_chan.ready;
   assign issue_fire = gen_active_ff && adv;

   // Restoring division of 2^16 by n - 1, MSB first.
   always_comb begin
      div_bit = (div_cnt_ff == '0);
      rem_sh  = {div_rem_ff, div_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff      <= DOT_W'(DOT_RESET);
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
         div_rem_ff  <= '0;
         div_quo_ff  <= '0;
      end else if (csr_fire) begin
         dot_ff      <= csr_chan.payload.dot_count;
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
         div_rem_ff  <= '0;
         div_quo_ff  <= '0;
      end else if (div_busy_ff) begin
         if (rem_sh >= {1'b0, d}) begin
            div_rem_ff <= IDX_W'(rem_sh - {1'b0, d});
            div_quo_ff <= {div_quo_ff[T_W-2:0], 1'b1};
         end else begin
            div_rem_ff <= rem_sh[IDX_W-1:0];
            div_quo_ff <= {div_quo_ff[T_W-2:0], 1'b0};
         end
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
         if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   // Exact t stepping: quotient each step, plus one when the remainder wraps.
   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, div_rem_ff};
      last    = (idx_ff == d);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_active_ff <= 1'b0;
         idx_ff        <= '0;
         t_ff          <= '0;
         acc_ff        <= '0;
      end else if (req_fire) begin
         gen_active_ff <= 1'b1;
         idx_ff        <= '0;
         t_ff          <= '0;
         acc_ff        <= '0;
      end else if (issue_fire) begin
         if (last) begin
            gen_active_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (acc_sum >= {1'b0, d}) begin
               t_ff   <= t_ff + div_quo_ff + T_W'(1);
               acc_ff <= IDX_W'(acc_sum - {1'b0, d});
            end else begin
               t_ff   <= t_ff + div_quo_ff;
               acc_ff <= acc_sum[IDX_W-1:0];
            end
         end
      end
   end

   // Control points of the current request.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         points_ff <= req_chan.payload;
      end
   end

   always_comb begin
      issue.valid      = gen_active_ff;
      issue.last_point = last;
      issue.t          = t_ff;
      issue.points     = points_ff;
   end

   // The stepping must land exactly on 1.0 at the final point.
   a_last_t_one: assert property (@(posedge clock) disable iff (reset)
      gen_active_ff && last |-> t_ff == T_W'(T_ONE))
      else $error("final sample t is not 1.0");

   a_acc_below_d: assert property (@(posedge clock) disable iff (reset)
      gen_active_ff |-> acc_ff < d)
      else $error("t remainder accumulator out of range");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !gen_active_ff && !req_chan.ready)
      else $error("sampling while the step divider is busy");

   a_req_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> gen_active_ff && t_ff == '0 && idx_ff == '0)
      else $error("request did not start at t zero");

endmodule

`default_nettype wire

/* rtl/core/bezier_curve_sampler.sv */
// Each point passes from the sample sequencer through the registered interpolation pipeline.
// Throughput: one point per cycle unless the output stalls; a request of n points
// holds the input until the sample sequencer has issued all n values of t.
// After reset and after each dot_count write, a serial divider forms
// the t step; requests and register writes wait until it finishes.
// Reset is synchronous: dot_count returns to 10 and the pipeline empties.
`default_nettype none

module bezier_curve_sampler #(
   parameter int MAX_DOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   bzs_chan_if.sink   req_chan,
   bzs_chan_if.source rsp_chan,
   bzs_chan_if.sink   csr_chan
);
   import bzs_pkg::*;

   localparam int STAGES = 6;
   localparam int AXES   = 2;

   issue_type              issue;
   logic                   adv;
   logic [STAGES-1:0]      vld_ff;
   logic [STAGES-1:0]      last_ff;
   logic [T_W-1:0]         t_pipe_ff [4];

   logic signed [COORD_W-1:0] ctrl [AXES][4];
   logic signed [COORD_W-1:0] lv1  [AXES][3];
   logic signed [COORD_W-1:0] lv2  [AXES][2];
   logic signed [COORD_W-1:0] lv3  [AXES];

   // Sample sequencer.
   bzs_seq #(.MAX_DOTS(MAX_DOTS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .adv      (adv),
      .issue    (issue)
   );

   // The whole pipeline moves unless the output holds an untaken point.
   assign adv = !vld_ff[STAGES-1] || rsp_chan.ready;

   // Valid and last flags travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], issue.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff      <= {last_ff[STAGES-2:0], issue.last_point};
         t_pipe_ff[0] <= issue.t;
         t_pipe_ff[1] <= t_pipe_ff[0];
         t_pipe_ff[2] <= t_pipe_ff[1];
         t_pipe_ff[3] <= t_pipe_ff[2];
      end
   end

   // Control points sorted by axis.
   always_comb begin
      ctrl[0][0] = issue.points.p0_x;
      ctrl[0][1] = issue.points.p1_x;
      ctrl[0][2] = issue.points.p2_x;
      ctrl[0][3] = issue.points.p3_x;
      ctrl[1][0] = issue.points.p0_y;
      ctrl[1][1] = issue.points.p1_y;
      ctrl[1][2] = issue.points.p2_y;
      ctrl[1][3] = issue.points.p3_y;
   end

   // Three interpolation levels per axis, two stages each.
   for (genvar ax = 0; ax < AXES; ax++) begin : g_axis
      for (genvar k = 0; k < 3; k++) begin : g_lv1
         bzs_lerp u_lerp (
            .clock (clock),
            .en    (adv),
            .a     (ctrl[ax][k]),
            .b     (ctrl[ax][k+1]),
            .t     (issue.t),
            .y     (lv1[ax][k])
         );
      end
      for (genvar k = 0; k < 2; k++) begin : g_lv2
         bzs_lerp u_lerp (
            .clock (clock),
            .en    (adv),
            .a     (lv1[ax][k]),
            .b     (lv1[ax][k+1]),
            .t     (t_pipe_ff[1]),
            .y     (lv2[ax][k])
         );
      end
      bzs_lerp u_lerp3 (
         .clock (clock),
         .en    (adv),
         .a     (lv2[ax][0]),
         .b     (lv2[ax][1]),
         .t     (t_pipe_ff[3]),
         .y     (lv3[ax])
      );
   end

   // Output register is the last pipeline stage.
   assign rsp_chan.valid              = vld_ff[STAGES-1];
   assign rsp_chan.payload.point_x    = lv3[0];
   assign rsp_chan.payload.point_y    = lv3[1];
   assign rsp_chan.payload.last_point = last_ff[STAGES-1];

endmodule

`default_nettype wire
